@@ hdl/multicore_task_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// multicore task scheduler assertion macros
// concurrent assertion wrappers, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef MULTICORE_TASK_SCHEDULER_MACROS_SVH
`define MULTICORE_TASK_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define MTS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("scheduler assertion failed");
`define MTS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("scheduler forbidden condition");
`else
`define MTS_ASSERT(label, clk, rst_n, prop)
`define MTS_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hdl/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// types, sizes and codes shared by the task scheduler modules
// ----------------------------------------------------------------------------
package mts_pkg;
	localparam int TASKS = 16;
	localparam int CORES = 4;
	localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int CNT_W = $clog2(TASKS + 1);
	localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CORES = 1'b1;

	localparam logic PSA = 1'b0;
	localparam logic HRRF = 1'b1;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] EV_FINISH = 2'd0;
	localparam logic [1:0] EV_LOAD = 2'd1;
	localparam logic [1:0] EV_TICK_END = 2'd2;

	typedef struct packed {
		logic        op;
		logic [15:0] task_id;
		logic [15:0] priority_req;
		logic [15:0] arrive_time;
		logic [15:0] run_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  core;
		logic [15:0] event_task;
		logic [15:0] time_res;
		logic        all_done;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIN,
		S_RD,
		S_MUL,
		S_CMP,
		S_ASSIGN,
		S_END
	} state_t;

	typedef struct packed {
		logic tbl_add;
		logic rsel_fin;
		logic core_clr;
		logic core_inc;
		logic fin_emit;
		logic pick_init;
		logic idx_inc;
		logic cand_load;
		logic mul_en;
		logic cmp_en;
		logic assign_emit;
		logic end_emit;
	} cmd_t;

	typedef struct packed {
		logic op_tick;
		logic fin_hit;
		logic last_core;
		logic cand_ok;
		logic last_idx;
		logic best_valid;
		logic free_found;
		logic out_free;
	} sts_t;
endpackage

@@ hdl/mts_ctrl.sv @@
// ----------------------------------------------------------------------------
// mts_ctrl
// sequencer for table adds and the tick: finish scan, selection passes, end of tick
// ----------------------------------------------------------------------------
module mts_ctrl import mts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic first_q, first_d;
	logic second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b1;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		second_d = second_q;
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.op_tick) begin
						if (first_q) begin
							first_d = 1'b0;
							second_d = 1'b0;
							cmd.pick_init = 1'b1;
							state_d = S_RD;
						end else begin
							cmd.core_clr = 1'b1;
							state_d = S_FIN;
						end
					end else begin
						cmd.tbl_add = 1'b1;
					end
				end
			end
			S_FIN: begin
				cmd.rsel_fin = 1'b1;
				if (!sts.fin_hit || sts.out_free) begin
					cmd.fin_emit = sts.fin_hit;
					cmd.core_inc = 1'b1;
					if (sts.last_core) begin
						second_d = 1'b1;
						cmd.pick_init = 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (sts.cand_ok) begin
					cmd.cand_load = 1'b1;
					state_d = S_MUL;
				end else if (sts.last_idx) begin
					state_d = S_ASSIGN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp_en = 1'b1;
				if (sts.last_idx) begin
					state_d = S_ASSIGN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_RD;
				end
			end
			S_ASSIGN: begin
				if (!sts.best_valid || !sts.free_found) begin
					if (second_q) begin
						state_d = S_END;
					end else begin
						cmd.core_clr = 1'b1;
						state_d = S_FIN;
					end
				end else if (sts.out_free) begin
					cmd.assign_emit = 1'b1;
					cmd.pick_init = 1'b1;
					state_d = S_RD;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.end_emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ hdl/mts_datapath.sv @@
// ----------------------------------------------------------------------------
// mts_datapath
// task table, core state, ratio cross products and the result register
// ----------------------------------------------------------------------------
`include "multicore_task_scheduler_macros.svh"
module mts_datapath import mts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	output out_item_t            out_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  cmd_t                 cmd,
	output sts_t                 sts
);
	logic             mode_q;
	logic [4:0]       ncores_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      time_q;

	logic [15:0] prio_q [TASKS];
	logic [15:0] arr_q [TASKS];
	logic [15:0] len_q [TASKS];
	logic [15:0] id_q [TASKS];
	logic [15:0] beg_q [TASKS];
	logic [TASKS-1:0] begun_q;
	logic [TASKS-1:0] done_q;

	logic [CORES-1:0] busy_q;
	logic [IDX_W-1:0] ctask_q [CORES];
	logic [CORE_W-1:0] core_idx_q;
	logic [IDX_W-1:0] idx_q;

	logic             best_valid_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [15:0]      best_prio_q, best_arr_q, best_len_q, best_id_q;
	logic [IDX_W-1:0] cand_idx_q;
	logic [15:0]      cand_prio_q, cand_arr_q, cand_len_q, cand_id_q;
	logic [32:0]      prod_c_q, prod_b_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic [IDX_W-1:0] ra;
	logic [15:0]      rd_prio, rd_arr, rd_len, rd_id, rd_beg;
	logic [IDX_W-1:0] fin_task;
	logic [TASKS-1:0] done_next, cnt_mask;
	logic             all_done;
	logic [4:0]       lim;
	logic             free_found;
	logic [CORE_W-1:0] free_c;
	logic [16:0]      na_c, nb_b;
	logic             beats;
	logic             out_free;
	logic             emit;

	assign fin_task = ctask_q[core_idx_q];
	assign ra = cmd.rsel_fin ? fin_task : idx_q;
	assign rd_prio = prio_q[ra];
	assign rd_arr = arr_q[ra];
	assign rd_len = len_q[ra];
	assign rd_id = id_q[ra];
	assign rd_beg = beg_q[ra];

	always_comb begin
		for (int i = 0; i < TASKS; i++) begin
			cnt_mask[i] = (CNT_W'(i) < count_q);
		end
		done_next = done_q;
		if (cmd.fin_emit) begin
			done_next[fin_task] = 1'b1;
		end
		all_done = &(done_next | ~cnt_mask);
	end

	always_comb begin
		lim = (ncores_q > 5'(CORES)) ? 5'(CORES) : ncores_q;
		free_found = 1'b0;
		free_c = '0;
		for (int c = 0; c < CORES; c++) begin
			if (!free_found && !busy_q[c] && (5'(c) < lim)) begin
				free_found = 1'b1;
				free_c = CORE_W'(c);
			end
		end
	end

	assign na_c = 17'(time_q) - 17'(cand_arr_q) + 17'(cand_len_q);
	assign nb_b = 17'(time_q) - 17'(best_arr_q) + 17'(best_len_q);

	always_comb begin
		if (mode_q == HRRF) begin
			if (prod_c_q != prod_b_q) begin
				beats = prod_c_q > prod_b_q;
			end else begin
				beats = cand_id_q < best_id_q;
			end
		end else begin
			if (cand_prio_q != best_prio_q) begin
				beats = cand_prio_q < best_prio_q;
			end else begin
				beats = cand_id_q < best_id_q;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign emit = cmd.fin_emit || cmd.assign_emit || cmd.end_emit;

	assign sts.op_tick = (in_data.op == OP_TICK);
	assign sts.fin_hit = busy_q[core_idx_q] && ((time_q - rd_beg) >= rd_len);
	assign sts.last_core = (core_idx_q == CORE_W'(CORES - 1));
	assign sts.cand_ok = cnt_mask[idx_q] && !begun_q[idx_q] && (rd_arr <= time_q);
	assign sts.last_idx = (idx_q == IDX_W'(TASKS - 1));
	assign sts.best_valid = best_valid_q;
	assign sts.free_found = free_found;
	assign sts.out_free = out_free;

	assign out_data = out_q;
	assign out_valid = out_valid_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PSA;
			ncores_q <= 5'd4;
			count_q <= '0;
			time_q <= '0;
			begun_q <= '0;
			done_q <= '0;
			busy_q <= '0;
			core_idx_q <= '0;
			idx_q <= '0;
			best_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_NUM_CORES: ncores_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.tbl_add && (count_q < CNT_W'(TASKS))) begin
				begun_q[count_q[IDX_W-1:0]] <= 1'b0;
				done_q[count_q[IDX_W-1:0]] <= 1'b0;
				count_q <= count_q + 1'b1;
			end
			if (cmd.core_clr) begin
				core_idx_q <= '0;
			end else if (cmd.core_inc) begin
				core_idx_q <= core_idx_q + 1'b1;
			end
			if (cmd.fin_emit) begin
				done_q <= done_next;
				busy_q[core_idx_q] <= 1'b0;
			end
			if (cmd.pick_init) begin
				idx_q <= '0;
				best_valid_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.cmp_en && (!best_valid_q || beats)) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.assign_emit) begin
				busy_q[free_c] <= 1'b1;
				begun_q[best_idx_q] <= 1'b1;
			end
			if (cmd.end_emit && (time_q != 16'hFFFF)) begin
				time_q <= time_q + 16'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.tbl_add && (count_q < CNT_W'(TASKS))) begin
			id_q[count_q[IDX_W-1:0]] <= in_data.task_id;
			prio_q[count_q[IDX_W-1:0]] <= in_data.priority_req;
			arr_q[count_q[IDX_W-1:0]] <= in_data.arrive_time;
			len_q[count_q[IDX_W-1:0]] <= in_data.run_length;
		end
		if (cmd.cand_load) begin
			cand_idx_q <= idx_q;
			cand_prio_q <= rd_prio;
			cand_arr_q <= rd_arr;
			cand_len_q <= rd_len;
			cand_id_q <= rd_id;
		end
		if (cmd.mul_en) begin
			prod_c_q <= 33'(na_c) * 33'(best_len_q);
			prod_b_q <= 33'(nb_b) * 33'(cand_len_q);
		end
		if (cmd.cmp_en && (!best_valid_q || beats)) begin
			best_idx_q <= cand_idx_q;
			best_prio_q <= cand_prio_q;
			best_arr_q <= cand_arr_q;
			best_len_q <= cand_len_q;
			best_id_q <= cand_id_q;
		end
		if (cmd.assign_emit) begin
			ctask_q[free_c] <= best_idx_q;
			beg_q[best_idx_q] <= time_q;
		end
		if (cmd.fin_emit) begin
			out_q <= '{kind: EV_FINISH, core: 4'(core_idx_q), event_task: rd_id,
				time_res: time_q, all_done: all_done, last: 1'b0};
		end else if (cmd.assign_emit) begin
			out_q <= '{kind: EV_LOAD, core: 4'(free_c), event_task: best_id_q,
				time_res: time_q, all_done: all_done, last: 1'b0};
		end else if (cmd.end_emit) begin
			out_q <= '{kind: EV_TICK_END, core: 4'd0, event_task: 16'd0,
				time_res: time_q, all_done: all_done, last: 1'b1};
		end
	end

	`MTS_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(TASKS))
	`MTS_ASSERT(a_emit_free, clk, arst_n, emit |-> out_free)
	`MTS_ASSERT(a_one_emit, clk, arst_n, $onehot0({cmd.fin_emit, cmd.assign_emit, cmd.end_emit}))
	`MTS_ASSERT(a_assign_marks, clk, arst_n, cmd.assign_emit |=> begun_q[$past(best_idx_q)])
endmodule

@@ hdl/multicore_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// multicore_task_scheduler
// non-preemptive priority / response-ratio scheduler over a task table
// ----------------------------------------------------------------------------
// usage:
//  in channel (in_valid, in_stall, in_data) takes add and tick items;
//  out channel (out_valid, out_stall, out_data) delivers finish, load and
//  end-of-tick results, the end-of-tick one marked with last.
//  an add is taken and gives no result.
//  a tick has an accept step, a finish scan over the cores, an end step and,
//  for each selection pass, a read of every table entry, the cross-product
//  multiply and its compare for each eligible task, and an assign step; a
//  round has up to CORES + 1 passes, and the first tick runs two rounds.
//  in_stall is high while a tick is in work; a result waits in the output
//  register, and a stalled receiver holds the sequencer only when the next
//  result is ready to go, adding its stall cycles to the tick.
//  reset empties the table, frees all cores, clears the clock, sets mode
//  to priority and four cores in use.
//  cfg writes (mode, num_cores) must be made only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module multicore_task_scheduler import mts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	cmd_t cmd;
	sts_t sts;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
